@@ hdl/fwmd_pkg.sv @@
// ----------------------------------------------------------------------------
// fwmd_pkg
// Shared widths, command codes and status codes for the match-delete queue.
// ----------------------------------------------------------------------------
package fwmd_pkg;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam int CMD_W  = 2;
  localparam int ITEM_W = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam cmd_t CMD_PUSH   = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;
  localparam cmd_t CMD_READ   = 2'd3;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_MISS = 2'd2;

endpackage

@@ hdl/fifo_with_match_delete.sv @@
// ----------------------------------------------------------------------------
// fifo_with_match_delete
// Bounded queue of value tags with push, pop, delete-first-match and
// indexed read, kept in one synchronous memory used as a ring buffer.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Payload
// command   in         start && !busy           cmd, item_value, position
// result    out        done (one-cycle strobe)  out_value, hit, status,
//                                               occupancy, is_empty
//
// Push finishes at the accept; pop and indexed read wait for one memory
// read. Delete searches the entries one by one from the head, then shifts
// each entry behind the match up by one place; the entries searched and
// shifted together always make the count. A miss found at the accept (empty
// queue, null key, position out of range) finishes at the accept. The
// single read port of the entry memory sets this one-entry-per-step pace.
// The result strobe rises the cycle after the command finishes; busy is low
// again in that cycle, so the next item can be taken while it shows.
// Reset clears the control state, count, head pointer, idx and done; entries need no clearing.
// The receiver cannot stall: every result stands for exactly one cycle.
// ----------------------------------------------------------------------------
module fifo_with_match_delete #(
  parameter int DEPTH       = fwmd_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = fwmd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  fwmd_pkg::cmd_t              cmd,
  input  logic [fwmd_pkg::ITEM_W-1:0] item_value,
  input  logic [fwmd_pkg::POS_W-1:0]  position,
  output logic                        done,
  output logic [fwmd_pkg::ITEM_W-1:0] out_value,
  output logic                        hit,
  output fwmd_pkg::status_t           status,
  output logic [fwmd_pkg::OCC_W-1:0]  occupancy,
  output logic                        is_empty
);
  import fwmd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WAIT   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  // Map a logical offset from the head onto a ring address.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(off);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [ITEM_W-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[ITEM_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[OCC_W-1:0];
  endfunction

  // Control state
  logic [1:0]             state;
  cmd_t                   op;
  logic [VALUE_WIDTH-1:0] key;
  logic [AW-1:0]          head;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;

  // Entry memory and its ports
  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic                   accept;
  logic [63:0]            in_wide;
  logic [VALUE_WIDTH-1:0] key_in;
  logic                   full;
  logic                   pos_ok;
  logic [CW:0]            idx1;
  logic [CW:0]            idx2;
  logic [CW:0]            count_w;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign in_wide = 64'(item_value);
  assign key_in  = in_wide[VALUE_WIDTH-1:0];
  assign full    = (count == CW'(DEPTH));
  assign pos_ok  = (32'(position) < 32'(count));
  assign idx1    = (CW+1)'(idx) + (CW+1)'(1);
  assign idx2    = (CW+1)'(idx) + (CW+1)'(2);
  assign count_w = (CW+1)'(count);

  // Memory access steering: one read and one write per cycle. A shift step
  // writes entry idx while reading idx+2, so the two never meet.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUSH: begin
              wr_en   = !full;
              wr_addr = phys(head, count);
              wr_data = key_in;
            end
            CMD_POP: begin
              rd_en = (count != '0);
            end
            CMD_DELETE: begin
              rd_en = (key_in != '0) && (count != '0);
            end
            default: begin
              rd_en   = pos_ok;
              rd_addr = phys(head, CW'(position));
            end
          endcase
        end
      end
      S_SEARCH: begin
        // Fetch the next entry whether or not this one matched.
        rd_en   = (idx1 < count_w);
        rd_addr = phys(head, CW'(idx1));
      end
      S_SHIFT: begin
        // Move entry idx+1 up into idx; fetch idx+2 if it exists.
        wr_en   = 1'b1;
        wr_addr = phys(head, idx);
        wr_data = rd_data;
        rd_en   = (idx2 < count_w);
        rd_addr = phys(head, CW'(idx2));
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= cmd;
            key <= key_in;
            idx <= '0;
            case (cmd)
              CMD_PUSH: begin
                done      <= 1'b1;
                out_value <= '0;
                hit       <= 1'b0;
                if (full) begin
                  status    <= ST_FULL;
                  occupancy <= to_occ(count);
                  is_empty  <= (count == '0);
                end else begin
                  // Append at the tail; the memory write happens this edge.
                  count     <= count + CW'(1);
                  status    <= ST_OK;
                  occupancy <= to_occ(count + CW'(1));
                  is_empty  <= 1'b0;
                end
              end
              CMD_POP: begin
                if (count == '0) begin
                  done      <= 1'b1;
                  out_value <= '0;
                  hit       <= 1'b0;
                  status    <= ST_MISS;
                  occupancy <= to_occ(count);
                  is_empty  <= 1'b1;
                end else begin
                  state <= S_WAIT;
                end
              end
              CMD_DELETE: begin
                if ((key_in != '0) && (count != '0)) begin
                  state <= S_SEARCH;
                end else begin
                  // Null key or empty queue: nothing to remove.
                  done      <= 1'b1;
                  out_value <= '0;
                  hit       <= 1'b0;
                  status    <= ST_MISS;
                  occupancy <= to_occ(count);
                  is_empty  <= (count == '0);
                end
              end
              default: begin
                if (pos_ok) begin
                  state <= S_WAIT;
                end else begin
                  done      <= 1'b1;
                  out_value <= '0;
                  hit       <= 1'b0;
                  status    <= ST_MISS;
                  occupancy <= to_occ(count);
                  is_empty  <= (count == '0);
                end
              end
            endcase
          end
        end
        S_WAIT: begin
          // Read data for pop or indexed read has arrived.
          state     <= S_IDLE;
          done      <= 1'b1;
          out_value <= to_out(rd_data);
          hit       <= 1'b1;
          status    <= ST_OK;
          if (op == CMD_POP) begin
            head      <= phys(head, CW'(1));
            count     <= count - CW'(1);
            occupancy <= to_occ(count - CW'(1));
            is_empty  <= (count == CW'(1));
          end else begin
            occupancy <= to_occ(count);
            is_empty  <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (rd_data == key) begin
            if (idx1 < count_w) begin
              // Entries stand behind the match: close the gap.
              state <= S_SHIFT;
            end else begin
              // Match at the tail: drop it by pulling the tail back.
              state     <= S_IDLE;
              count     <= count - CW'(1);
              done      <= 1'b1;
              out_value <= '0;
              hit       <= 1'b1;
              status    <= ST_OK;
              occupancy <= to_occ(count - CW'(1));
              is_empty  <= (count == CW'(1));
            end
          end else if (idx1 < count_w) begin
            idx <= CW'(idx1);
          end else begin
            state     <= S_IDLE;
            done      <= 1'b1;
            out_value <= '0;
            hit       <= 1'b0;
            status    <= ST_MISS;
            occupancy <= to_occ(count);
            is_empty  <= 1'b0;
          end
        end
        S_SHIFT: begin
          if (idx2 < count_w) begin
            idx <= CW'(idx1);
          end else begin
            state     <= S_IDLE;
            count     <= count - CW'(1);
            done      <= 1'b1;
            out_value <= '0;
            hit       <= 1'b1;
            status    <= ST_OK;
            occupancy <= to_occ(count - CW'(1));
            is_empty  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_PUSH)) |=> done)
    else $error("push result not given in the next cycle");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (status == ST_OK))
    else $error("hit reported with a failing status");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result shown while a command is still running");

  a_shift_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (count_w >= (CW+1)'(2)))
    else $error("shift step with fewer than two entries");

endmodule

@@ tb/tb_fifo_with_match_delete.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_with_match_delete
// Self-checking testbench for the match-delete queue. Drives push, pop,
// delete-first-match and indexed-read items through the start/busy
// handshake. A shadow copy of the queue predicts every result, and each
// done strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fifo_with_match_delete;
  import fwmd_pkg::*;

  localparam int QUEUE_DEPTH   = DEPTH_DEFAULT;
  // A delete over a full queue is the longest command; the settle wait must outlast it.
  localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 470;

  typedef struct packed {
    logic [ITEM_W-1:0] out_value;
    logic              hit;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
  } queue_result_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              start      = 1'b0;
  cmd_t              cmd        = CMD_PUSH;
  logic [ITEM_W-1:0] item_value = '0;
  logic [POS_W-1:0]  position   = '0;
  logic              busy;
  logic              done;
  logic [ITEM_W-1:0] out_value;
  logic              hit;
  status_t           status;
  logic [OCC_W-1:0]  occupancy;
  logic              is_empty;

  // Shadow copy of the queue: head at index 0, as the block presents it.
  logic [ITEM_W-1:0] shadow_entries [QUEUE_DEPTH];
  int                shadow_count = 0;

  queue_result_t     pending_results [$];
  int                sender_idle_pct = 0;
  int unsigned       cycle_count     = 0;
  int                errors          = 0;
  int                items_sent      = 0;
  int                results_checked = 0;
  int                hits_seen       = 0;
  int                fulls_seen      = 0;
  int                misses_seen     = 0;

  fifo_with_match_delete dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .item_value (item_value),
    .position   (position),
    .done       (done),
    .out_value  (out_value),
    .hit        (hit),
    .status     (status),
    .occupancy  (occupancy),
    .is_empty   (is_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Guard against a hang: stop the run if it far outlasts the slowest pass.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Close the gap left at idx; the entries behind it move one place up.
  function automatic void shift_out_entry(int idx);
    for (int i = idx; i + 1 < shadow_count; i++) begin
      shadow_entries[i] = shadow_entries[i + 1];
    end
    shadow_count--;
  endfunction

  // Apply one command to the shadow queue and return the result it causes.
  function automatic queue_result_t predict_queue_result(cmd_t c, logic [ITEM_W-1:0] v,
                                                         logic [POS_W-1:0] p);
    queue_result_t r;
    int            match_idx;
    r         = '0;
    r.status  = ST_OK;
    match_idx = -1;
    case (c)
      CMD_PUSH: begin
        // A full queue stores nothing; zero is stored like any other value.
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_MISS;
        end else begin
          r.out_value = shadow_entries[0];
          r.hit       = 1'b1;
          shift_out_entry(0);
        end
      end
      CMD_DELETE: begin
        // Zero is the null value and never matches, even when stored.
        if (v != '0) begin
          for (int i = 0; i < shadow_count; i++) begin
            if (match_idx < 0 && shadow_entries[i] == v) match_idx = i;
          end
        end
        if (match_idx >= 0) begin
          r.hit = 1'b1;
          shift_out_entry(match_idx);
        end else begin
          r.status = ST_MISS;
        end
      end
      default: begin
        if (int'(p) < shadow_count) begin
          r.out_value = shadow_entries[p];
          r.hit       = 1'b1;
        end else begin
          r.status = ST_MISS;
        end
      end
    endcase
    r.occupancy = OCC_W'(shadow_count);
    r.is_empty  = (shadow_count == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [ITEM_W-1:0] want,
                             input logic [ITEM_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
    end
  endtask

  // Sample in the active region of the edge: the outputs still hold the
  // values of the cycle that this edge closes.
  always @(posedge clk) begin : result_checker
    queue_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual value %h hit %b status %0d",
                 $realtime, out_value, hit, status);
      end else begin
        want = pending_results.pop_front();
        check_field("out_value", want.out_value, out_value);
        check_field("hit",       ITEM_W'(want.hit),       ITEM_W'(hit));
        check_field("status",    ITEM_W'(want.status),    ITEM_W'(status));
        check_field("occupancy", ITEM_W'(want.occupancy), ITEM_W'(occupancy));
        check_field("is_empty",  ITEM_W'(want.is_empty),  ITEM_W'(is_empty));
        results_checked++;
        if (want.hit) hits_seen++;
        if (want.status == ST_FULL) fulls_seen++;
        if (want.status == ST_MISS) misses_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offer one item and hold it until the block takes it. Start stays high
  // when no idle cycle follows, so back-to-back items need no lowering.
  task automatic send_item(input cmd_t c, input logic [ITEM_W-1:0] v,
                           input logic [POS_W-1:0] p);
    start      <= 1'b1;
    cmd        <= c;
    item_value <= v;
    position   <= p;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(predict_queue_result(c, v, p));
    items_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Hold off until every predicted result has arrived, then let the
  // longest command run out.
  task automatic wait_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Commands on an empty queue: all of them miss and nothing changes.
  task automatic test_empty_queue();
    sender_idle_pct = 0;
    send_item(CMD_POP,    32'h0000_0000, 4'd0);
    send_item(CMD_DELETE, 32'h1234_5678, 4'd0);
    send_item(CMD_DELETE, 32'h0000_0000, 4'd0);
    send_item(CMD_READ,   32'h0000_0000, 4'd0);
    wait_until_drained();
  endtask

  // Fill to capacity with extreme values, a zero at the head, then push once
  // more to see full, and read the deepest slot.
  task automatic test_fill_and_full();
    sender_idle_pct = 6;
    send_item(CMD_PUSH, 32'h0000_0000, 4'd0);
    send_item(CMD_PUSH, 32'hFFFF_FFFF, 4'd15);
    send_item(CMD_PUSH, 32'hAAAA_AAAA, 4'd0);
    send_item(CMD_PUSH, 32'h5555_5555, 4'd15);
    for (int i = 4; i < QUEUE_DEPTH; i++) begin
      send_item(CMD_PUSH, $urandom(), 4'($urandom_range(15)));
    end
    send_item(CMD_PUSH, 32'hDEAD_0001, 4'd0);
    send_item(CMD_READ, 32'h0000_0000, 4'd15);
    wait_until_drained();
  endtask

  // Deletes of the tail, of an absent value and of the null value, then pop
  // the stored zero from the head.
  task automatic test_special_deletes();
    sender_idle_pct = 0;
    send_item(CMD_DELETE, shadow_entries[shadow_count - 1], 4'd0);
    send_item(CMD_DELETE, 32'h0BAD_CAFE, 4'd0);
    send_item(CMD_DELETE, 32'h0000_0000, 4'd0);
    send_item(CMD_POP,    32'h0000_0000, 4'd0);
    wait_until_drained();
  endtask

  // Random traffic that swings between filling and draining so that the
  // queue keeps passing through empty and full. Deletes mostly aim at stored
  // values; a small share of items is pure noise.
  task automatic run_random_phase(input int n_items, input int idle_pct);
    logic [ITEM_W-1:0] pool [8];
    bit                filling;
    int                r;
    int                pick;
    cmd_t              c;
    logic [ITEM_W-1:0] v;
    logic [POS_W-1:0]  p;
    sender_idle_pct = idle_pct;
    filling         = 1'b1;
    foreach (pool[i]) pool[i] = $urandom();
    pool[0] = 32'hFFFF_FFFF;
    for (int n = 0; n < n_items; n++) begin
      if (shadow_count >= QUEUE_DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      if (shadow_count == 0 && $urandom_range(2) == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (r < 5) begin
        c = cmd_t'($urandom_range(3));
        v = $urandom();
        p = POS_W'($urandom_range(15));
      end else begin
        if (filling) begin
          c = (r < 60) ? CMD_PUSH : (r < 73) ? CMD_POP : (r < 86) ? CMD_DELETE : CMD_READ;
        end else begin
          c = (r < 20) ? CMD_PUSH : (r < 55) ? CMD_POP : (r < 80) ? CMD_DELETE : CMD_READ;
        end
        pick = $urandom_range(99);
        if (c == CMD_DELETE && shadow_count > 0 && pick < 70) begin
          v = shadow_entries[$urandom_range(shadow_count - 1)];
        end else if (pick < 80) begin
          v = pool[$urandom_range(7)];
        end else if (pick < 90) begin
          v = '0;
        end else begin
          v = $urandom();
        end
        pick = $urandom_range(shadow_count);
        if ($urandom_range(9) < 7) p = POS_W'((pick > 15) ? 15 : pick);
        else p = POS_W'($urandom_range(15));
      end
      send_item(c, v, p);
      // Pause once per phase until the block has caught up.
      if (n == n_items / 2) wait_until_drained();
    end
    wait_until_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_fill_and_full();
    test_special_deletes();
    run_random_phase(PHASE_ITEMS, 6);
    run_random_phase(PHASE_ITEMS, 85);
    run_random_phase(PHASE_ITEMS, 0);

    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0t: %0d expected results never arrived", $realtime, pending_results.size());
    end
    $display("Run covered %0d items and %0d results: %0d hits, %0d full, %0d misses.",
             items_sent, results_checked, hits_seen, fulls_seen, misses_seen);
    $display("Sender gaps of 0, 6 and 85 percent; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/fwmd_pkg.sv
hdl/fifo_with_match_delete.sv
tb/tb_fifo_with_match_delete.sv
